// ===== sv/affine_transform_accumulator_top_assert.svh =====
// Assertion macros for the affine transform accumulator.
// Used by the top level; needs i_clk and i_rst_n in scope.
`ifndef AFFINE_TRANSFORM_ACCUMULATOR_TOP_ASSERT_SVH
`define AFFINE_TRANSFORM_ACCUMULATOR_TOP_ASSERT_SVH

// checked only out of reset
`define ATACC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ATACC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/atacc_pkg.sv =====
// Shared types and constants of the affine transform accumulator.
// No dependencies.
`default_nettype none

package atacc_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int XY_W         = 34;
    localparam int ACC_W        = 67;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
    localparam logic signed [31:0] FIX_ONE = 32'(1) <<< FRAC_BITS;

    typedef enum logic [1:0] {
        FUNC_IDENT = 2'd0,
        FUNC_MOVE  = 2'd1,
        FUNC_ROT   = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_MAC,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic [15:0]        rotate_angle;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
    } t_out_res;

    // one multiply-accumulate step issued to the MAC unit
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [3:0] idx;
    } t_mac_op;

    typedef struct packed {
        logic       valid;
        logic [3:0] idx;
    } t_mac_wr;

    // arctangent of 2^-i in units of 2^32 per turn
    function automatic logic [31:0] atan_units(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/atacc_cordic.sv =====
// Iterative CORDIC: sine and cosine of a binary angle, one step per cycle.
// Depends on atacc_pkg.
`default_nettype none

module atacc_cordic import atacc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [15:0]        i_angle,
    output logic                    o_done,
    output logic signed [31:0]      o_cos,
    output logic signed [31:0]      o_sin
);

    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [XY_W-1:0] HALF = XY_W'(1) <<< (SH - 1);

    logic                   r_run, r_fin, r_done;
    logic [4:0]             r_cnt;
    logic [1:0]             r_quad;
    logic signed [XY_W-1:0] r_x, r_y, r_z;
    logic signed [31:0]     r_cos, r_sin;

    logic signed [XY_W-1:0] dx, dy, at, z0, xr, yr;
    logic signed [31:0]     c, s;
    logic [ANGLE_BITS-1:0]  ang;

    assign ang = i_angle[ANGLE_BITS-1:0];
    assign z0  = $signed({{(XY_W-30){1'b0}}, ang[ANGLE_BITS-3:0],
                          {(32-ANGLE_BITS){1'b0}}});
    assign dx  = r_y >>> r_cnt;
    assign dy  = r_x >>> r_cnt;
    assign at  = $signed({{(XY_W-32){1'b0}}, atan_units(r_cnt)});
    assign xr  = (r_x + HALF) >>> SH;
    assign yr  = (r_y + HALF) >>> SH;
    assign c   = xr[31:0];
    assign s   = yr[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= z0;
            r_quad <= ang[ANGLE_BITS-1 -: 2];
        end else if (r_run) begin
            if (!r_z[XY_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
        if (r_fin) begin
            case (r_quad)
                2'd0: begin r_cos <= c;  r_sin <= s;  end
                2'd1: begin r_cos <= -s; r_sin <= c;  end
                2'd2: begin r_cos <= -c; r_sin <= -s; end
                default: begin r_cos <= s; r_sin <= -c; end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

`default_nettype wire

// ===== sv/atacc_mac.sv =====
// Shared multiply-accumulate unit: registered 32x32 product, 67-bit sum,
// round to nearest at FRAC_BITS and saturate. Depends on atacc_pkg.
`default_nettype none

module atacc_mac import atacc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_mac_op            i_op,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output t_mac_wr                 o_wr,
    output logic signed [31:0]      o_data
);

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

    t_mac_op                  r_s1, r_s2;
    logic signed [63:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= i_op;
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
        if (r_s1.valid) begin
            r_acc <= r_s1.first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    assign rnd = (r_acc + HALF) >>> FRAC_BITS;

    always_comb begin
        if (rnd[ACC_W-1:31] == '0 || rnd[ACC_W-1:31] == '1) begin
            o_data = rnd[31:0];
        end else if (rnd[ACC_W-1]) begin
            o_data = 32'sh8000_0000;
        end else begin
            o_data = 32'sh7FFF_FFFF;
        end
    end

    assign o_wr.valid = r_s2.valid & r_s2.last;
    assign o_wr.idx   = r_s2.idx;

endmodule

`default_nettype wire

// ===== sv/affine_transform_accumulator_top.sv =====
// Keeps a 3x3 Q16.16 transform and applies one command per request,
// returning the full matrix after each. Identity and unused commands go
// straight to the result; translate runs 12 multiply-accumulate steps on
// the one shared 32x32 multiplier and then drains its pipeline; rotate
// first runs 24 CORDIC steps and rounds and hands over sine and cosine,
// ahead of the same multiply and drain steps. One request at a time;
// o_stall is high until the result is taken.
// Depends on atacc_pkg, atacc_cordic, atacc_mac.
`default_nettype none

module affine_transform_accumulator_top import atacc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_req  i_req,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_res      o_res
);

    `include "affine_transform_accumulator_top_assert.svh"

    t_state              r_state, n_state;
    logic [3:0]          r_k, n_k;
    logic                r_d, n_d;
    t_func               r_func, n_func;
    logic signed [31:0]  r_mx, r_my;
    logic signed [31:0]  r_m [0:8];

    logic                cord_start, cord_done;
    logic signed [31:0]  cos_v, sin_v;
    t_mac_op             op;
    t_mac_wr             wr;
    logic signed [31:0]  mac_a, mac_b, mac_q;
    logic [1:0]          row, a_col;
    logic                col, term;
    logic [3:0]          a_idx;
    logic                load_ident;

    assign row  = r_k[3:2];
    assign col  = r_k[1];
    assign term = r_k[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_d     <= 1'b0;
            r_func  <= FUNC_IDENT;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_d     <= n_d;
            r_func  <= n_func;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_d        = r_d;
        n_func     = r_func;
        cord_start = 1'b0;
        load_ident = 1'b0;
        op         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func = t_func'(i_req.func);
                    n_k    = '0;
                    case (t_func'(i_req.func))
                        FUNC_IDENT: begin
                            load_ident = 1'b1;
                            n_state    = S_OUT;
                        end
                        FUNC_MOVE: n_state = S_MAC;
                        FUNC_ROT: begin
                            cord_start = 1'b1;
                            n_state    = S_ROT;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_ROT: begin
                if (cord_done) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                op.valid = 1'b1;
                op.first = ~term;
                op.last  = term;
                op.idx   = 4'(row) * 4'd3 + 4'(col);
                n_k      = r_k + 4'd1;
                if (r_k == 4'd11) begin
                    n_state = S_DRAIN;
                    n_d     = 1'b0;
                end
            end
            S_DRAIN: begin
                n_d = 1'b1;
                if (r_d) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // operand select; column 2 of the product is column 2 of the old matrix
    always_comb begin
        if (r_func == FUNC_MOVE) begin
            a_col = term ? 2'd2 : 2'(col);
            if (!term) begin
                mac_b = FIX_ONE;
            end else begin
                mac_b = col ? r_my : r_mx;
            end
        end else begin
            a_col = 2'(term);
            case ({col, term})
                2'b00:   mac_b = cos_v;
                2'b01:   mac_b = sin_v;
                2'b10:   mac_b = -sin_v;
                default: mac_b = cos_v;
            endcase
        end
        a_idx = 4'(row) * 4'd3 + 4'(a_col);
        mac_a = r_m[a_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_mx <= i_req.move_x;
            r_my <= i_req.move_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || load_ident) begin
            for (int i = 0; i < 9; i++) begin
                r_m[i] <= (i % 4 == 0) ? FIX_ONE : 32'sd0;
            end
        end else if (wr.valid) begin
            r_m[wr.idx] <= mac_q;
        end
    end

    atacc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_angle (i_req.rotate_angle),
        .o_done  (cord_done),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    atacc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_wr    (wr),
        .o_data  (mac_q)
    );

    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign o_res.m00 = r_m[0];
    assign o_res.m01 = r_m[1];
    assign o_res.m02 = r_m[2];
    assign o_res.m10 = r_m[3];
    assign o_res.m11 = r_m[4];
    assign o_res.m12 = r_m[5];
    assign o_res.m20 = r_m[6];
    assign o_res.m21 = r_m[7];
    assign o_res.m22 = r_m[8];

    `ATACC_ASSERT(a_busy_while_out, o_valid |-> o_stall, "result shown while accepting")
    `ATACC_ASSERT(a_wr_window, wr.valid |-> (r_state == S_MAC || r_state == S_DRAIN), "stray write")
    `ATACC_ASSERT(a_cordic_done, cord_done |-> (r_state == S_ROT), "CORDIC done outside rotate")
    `ATACC_ASSERT_ALWAYS(a_no_write_in_reset, !i_rst_n |=> !wr.valid, "MAC write after reset")

endmodule

`default_nettype wire
